/* rtl/mtd_pkg.sv */
`timescale 1ns / 1ps

package mtd_pkg;

  localparam int MAX_CODE_ELEMENTS_DEF = 4;
  localparam int RUN_COUNT_BITS_DEF    = 4;

  localparam int CHAR_W       = 7;
  localparam int CFG_W        = 4;
  localparam int MAX_RESULTS  = 4;
  localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int NUM_LETTERS  = 26;
  localparam int LETTER_MAX_LEN = 4;

  localparam logic [CFG_W-1:0] DASH_UNITS_RST       = 4'd3;
  localparam logic [CFG_W-1:0] LETTER_GAP_UNITS_RST = 4'd3;
  localparam logic [CFG_W-1:0] WORD_GAP_UNITS_RST   = 4'd7;

  localparam logic [CHAR_W-1:0] CHAR_A       = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_STAR    = 7'h2A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

  typedef enum logic [1:0] {
    CFG_DASH_UNITS       = 2'd0,
    CFG_LETTER_GAP_UNITS = 2'd1,
    CFG_WORD_GAP_UNITS   = 2'd2
  } cfg_idx_t;

  // element i of a letter is bit i, 1 = dash
  localparam logic [2:0] CODE_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] CODE_BITS [NUM_LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  typedef struct packed {
    logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;  // chars[0] goes out first
    logic [RES_CNT_W-1:0]               count;
  } burst_t;

  function automatic logic [CHAR_W-1:0] decode_letter(input logic [2:0] len,
                                                      input logic [3:0] bits);
    logic [CHAR_W-1:0] c;
    c = CHAR_STAR;
    if (len >= 3'd1 && len <= 3'(LETTER_MAX_LEN)) begin
      for (int i = 0; i < NUM_LETTERS; i++) begin
        if (CODE_LEN[i] == len && CODE_BITS[i] == bits) begin
          c = CHAR_A + CHAR_W'(i);
        end
      end
    end
    return c;
  endfunction

endpackage

/* rtl/mtd_core.sv */
`timescale 1ns / 1ps

module mtd_core #(
  parameter int MAX_CODE_ELEMENTS = mtd_pkg::MAX_CODE_ELEMENTS_DEF,
  parameter int RUN_COUNT_BITS    = mtd_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [mtd_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_fire,
  input  logic                       sample_level,
  input  logic                       line_end,
  output mtd_pkg::burst_t            burst
);
  import mtd_pkg::*;

  localparam int LEN_W = $clog2(MAX_CODE_ELEMENTS + 2);
  localparam int IDX_W = $clog2(MAX_CODE_ELEMENTS);
  localparam int CMP_W = (RUN_COUNT_BITS > CFG_W) ? RUN_COUNT_BITS : CFG_W;
  localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [MAX_CODE_ELEMENTS-1:0] bits;
    logic [LEN_W-1:0]             len;
    logic                         emit_letter;
    logic                         emit_space;
    logic [CHAR_W-1:0]            letter;
  } close_t;

  logic [CFG_W-1:0] dash_units_r, letter_gap_r, word_gap_r;

  logic                         prev_r, prev_nxt;
  logic                         started_r, started_nxt;
  logic [RUN_COUNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                         gap_r, gap_nxt;
  logic [MAX_CODE_ELEMENTS-1:0] bits_r, bits_nxt;
  logic [LEN_W-1:0]             len_r, len_nxt;

  function automatic logic run_eq(input logic [RUN_COUNT_BITS-1:0] cnt,
                                  input logic [CFG_W-1:0] units);
    return CMP_W'(cnt) == CMP_W'(units);
  endfunction

  function automatic close_t close_run(input logic gap,
                                       input logic [RUN_COUNT_BITS-1:0] cnt,
                                       input logic [MAX_CODE_ELEMENTS-1:0] bits,
                                       input logic [LEN_W-1:0] len,
                                       input logic [CFG_W-1:0] dash_u,
                                       input logic [CFG_W-1:0] letter_u,
                                       input logic [CFG_W-1:0] word_u);
    close_t r;
    r.bits        = bits;
    r.len         = len;
    r.emit_letter = 1'b0;
    r.emit_space  = 1'b0;
    r.letter      = decode_letter(3'(len), bits[3:0]);
    if (gap) begin
      // word gap is tested first so equal gap settings give letter + space
      if (run_eq(cnt, word_u)) begin
        r.emit_letter = 1'b1;
        r.emit_space  = 1'b1;
        r.bits        = '0;
        r.len         = '0;
      end else if (run_eq(cnt, letter_u)) begin
        r.emit_letter = 1'b1;
        r.bits        = '0;
        r.len         = '0;
      end
    end else if (len < LEN_W'(MAX_CODE_ELEMENTS)) begin
      if (run_eq(cnt, dash_u)) begin
        r.bits[len[IDX_W-1:0]] = 1'b1;
      end
      r.len = len + LEN_W'(1);
    end else begin
      r.len = LEN_W'(MAX_CODE_ELEMENTS + 1);  // over-long marker
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_units_r <= DASH_UNITS_RST;
      letter_gap_r <= LETTER_GAP_UNITS_RST;
      word_gap_r   <= WORD_GAP_UNITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_DASH_UNITS:       dash_units_r <= cfg_wdata;
        CFG_LETTER_GAP_UNITS: letter_gap_r <= cfg_wdata;
        CFG_WORD_GAP_UNITS:   word_gap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    close_t c1, c2;
    logic [CHAR_W-1:0]    last_letter;
    logic [RES_CNT_W-1:0] n;

    burst       = '0;
    n           = '0;
    started_nxt = started_r;
    cnt_nxt     = cnt_r;
    gap_nxt     = gap_r;
    bits_nxt    = bits_r;
    len_nxt     = len_r;
    c1          = '0;
    c2          = '0;
    last_letter = CHAR_STAR;

    if (!started_r) begin
      started_nxt = 1'b1;
      cnt_nxt     = RUN_COUNT_BITS'(1);
      gap_nxt     = 1'b0;
      bits_nxt    = '0;
      len_nxt     = '0;
    end else if (sample_level != prev_r) begin
      c1 = close_run(gap_r, cnt_r, bits_r, len_r, dash_units_r, letter_gap_r, word_gap_r);
      bits_nxt = c1.bits;
      len_nxt  = c1.len;
      if (c1.emit_letter) begin
        burst.chars[n[1:0]] = c1.letter;
        n = n + RES_CNT_W'(1);
      end
      if (c1.emit_space) begin
        burst.chars[n[1:0]] = CHAR_SPACE;
        n = n + RES_CNT_W'(1);
      end
      cnt_nxt = RUN_COUNT_BITS'(1);
      gap_nxt = ~gap_r;
    end else if (cnt_r < RUN_MAX) begin
      cnt_nxt = cnt_r + RUN_COUNT_BITS'(1);
    end
    prev_nxt = sample_level;

    if (line_end) begin
      c2 = close_run(gap_nxt, cnt_nxt, bits_nxt, len_nxt,
                     dash_units_r, letter_gap_r, word_gap_r);
      if (c2.emit_letter) begin
        burst.chars[n[1:0]] = c2.letter;
        n = n + RES_CNT_W'(1);
      end
      if (c2.emit_space) begin
        burst.chars[n[1:0]] = CHAR_SPACE;
        n = n + RES_CNT_W'(1);
      end
      last_letter = decode_letter(3'(c2.len), c2.bits[3:0]);
      burst.chars[n[1:0]] = last_letter;
      n = n + RES_CNT_W'(1);
      burst.chars[n[1:0]] = CHAR_NEWLINE;
      n = n + RES_CNT_W'(1);
      started_nxt = 1'b0;
      cnt_nxt     = '0;
      gap_nxt     = 1'b0;
      bits_nxt    = '0;
      len_nxt     = '0;
    end
    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= 1'b0;
      started_r <= 1'b0;
      cnt_r     <= '0;
      gap_r     <= 1'b0;
      bits_r    <= '0;
      len_r     <= '0;
    end else if (in_fire) begin
      prev_r    <= prev_nxt;
      started_r <= started_nxt;
      cnt_r     <= cnt_nxt;
      gap_r     <= gap_nxt;
      bits_r    <= bits_nxt;
      len_r     <= len_nxt;
    end
  end

`ifndef SYNTHESIS
  a_line_end_two_chars: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && line_end |-> burst.count >= RES_CNT_W'(2))
    else $error("line end must give a letter and a newline");
  a_line_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && line_end |=> !started_r && cnt_r == '0)
    else $error("line state not cleared after line end");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_CODE_ELEMENTS + 1))
    else $error("symbol length out of range");
`endif

endmodule

/* rtl/mtd_out_buf.sv */
`timescale 1ns / 1ps

module mtd_out_buf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  output logic                        accept_ok,
  input  mtd_pkg::burst_t             burst_in,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mtd_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_last
);
  import mtd_pkg::*;

  burst_t burst_r, burst_nxt;
  logic   out_fire;

  assign out_tvalid = burst_r.count != '0;
  assign out_fire   = out_tvalid && out_tready;
  assign out_char   = burst_r.chars[0];
  assign out_last   = burst_r.count == RES_CNT_W'(1);
  // take a new request once the pending burst is gone or its last char leaves now
  assign accept_ok  = (burst_r.count == '0) || (out_last && out_tready);

  always_comb begin
    burst_nxt = burst_r;
    if (in_fire) begin
      burst_nxt = burst_in;
    end else if (out_fire) begin
      burst_nxt.chars = burst_r.chars >> CHAR_W;
      burst_nxt.count = burst_r.count - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r.count <= '0;
    end else begin
      burst_r.count <= burst_nxt.count;
    end
    burst_r.chars <= burst_nxt.chars;
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> burst_r.count == '0 || (burst_r.count == RES_CNT_W'(1) && out_fire))
    else $error("pending characters overwritten");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r.count <= RES_CNT_W'(MAX_RESULTS))
    else $error("burst count out of range");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && burst_in.count != '0 |=> out_tvalid)
    else $error("loaded burst not presented");
`endif

endmodule

/* rtl/morse_timing_decoder_top.sv */
`timescale 1ns / 1ps

// Morse timing decoder. Each input request is one time-unit sample of a keyed
// line (tdata bit 0 = level, tlast = last sample of the line); runs of equal
// samples alternate mark/gap, the first run of each line being a mark. A sample
// is taken and its 0 to 4 result characters (A-Z, '*', space,
// newline; tlast on the last one of the burst) are then sent one per cycle, while
// out_tready is high, from the output buffer. The next sample is taken in the same
// cycle as the last character of the previous burst is taken, so a new sample waits
// until that burst drains; samples with no result go through at one per cycle.
// Thresholds are written through the cfg port (0 dash, 1 letter gap, 2 word gap);
// the user must write them only while idle, as the block does not enforce this.
module morse_timing_decoder_top #(
  parameter int MAX_CODE_ELEMENTS = mtd_pkg::MAX_CODE_ELEMENTS_DEF,
  parameter int RUN_COUNT_BITS    = mtd_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [mtd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [0] sample_level, [7:1] zero
  input  logic                      in_tlast,   // line_end
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // [6:0] char_code, [7] zero
  output logic                      out_tlast   // ends_burst
);
  import mtd_pkg::*;

  logic              in_fire;
  burst_t            burst;
  logic [CHAR_W-1:0] out_char;

  assign in_fire   = in_tvalid && in_tready;
  assign out_tdata = {1'b0, out_char};

  mtd_core #(
    .MAX_CODE_ELEMENTS (MAX_CODE_ELEMENTS),
    .RUN_COUNT_BITS    (RUN_COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_fire      (in_fire),
    .sample_level (in_tdata[0]),
    .line_end     (in_tlast),
    .burst        (burst)
  );

  mtd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .accept_ok  (in_tready),
    .burst_in   (burst),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

endmodule
